@@ sv/rlbce_pkg.sv @@
// ----------------------------------------------------------------------------
// rlbce_pkg
// shared types and constants of the ring line block copy engine
// ----------------------------------------------------------------------------
package rlbce_pkg;

  localparam int LINE_PIXELS = 1024;
  localparam int ADDR_W      = $clog2(LINE_PIXELS);
  localparam int PIX_W       = 16;
  localparam int LEN_W       = ADDR_W + 1;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_COPY  = 2'd2;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] len_m1;   // saturated length minus one
    logic              upward;   // copy runs from the first pixel up
  } cmd_t;

endpackage

@@ sv/rlbce_front.sv @@
// ----------------------------------------------------------------------------
// rlbce_front
// accepts words, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module rlbce_front
  import rlbce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [ADDR_W-1:0] pixel_addr,
  input  logic [PIX_W-1:0]  pixel_value,
  input  logic [ADDR_W-1:0] copy_source,
  input  logic [ADDR_W-1:0] copy_dest,
  input  logic [LEN_W-1:0]  copy_length,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             queue [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  cmd_t             cls;
  logic             do_push;
  logic             do_pop;
  logic [LEN_W-1:0] len_sat;

  // zero or overlong length means the whole line
  always_comb begin
    if (copy_length == '0 || copy_length > LEN_W'(LINE_PIXELS)) begin
      len_sat = LEN_W'(LINE_PIXELS);
    end else begin
      len_sat = copy_length;
    end
    cls.op     = opcode;
    cls.addr   = pixel_addr;
    cls.value  = pixel_value;
    cls.src    = copy_source;
    cls.dst    = copy_dest;
    cls.len_m1 = ADDR_W'(len_sat - LEN_W'(1));
    cls.upward = (copy_dest <= copy_source);
  end

  assign full      = (count == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

@@ sv/rlbce_back.sv @@
// ----------------------------------------------------------------------------
// rlbce_back
// line store, pixel access and element copy sequencer with result register
// ----------------------------------------------------------------------------
module rlbce_back
  import rlbce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  output logic [PIX_W-1:0]  read_value,
  output logic              copy_done,
  input  logic              out_pop
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_CP_RD, S_CP_WR} state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr;
  logic [ADDR_W-1:0] cnt;
  cmd_t              cur;
  logic [ADDR_W-1:0] off;

  logic [PIX_W-1:0]  mem [LINE_PIXELS];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [PIX_W-1:0]  wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;

  assign cmd_pop = (state == S_IDLE) && cmd_valid && !out_valid;
  assign off     = cur.upward ? cnt : (cur.len_m1 - cnt);

  always_comb begin
    we    = 1'b0;
    waddr = cmd.addr;
    wdata = cmd.value;
    re    = 1'b0;
    raddr = cmd.addr;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      S_IDLE: begin
        we = cmd_pop && (cmd.op == OP_WRITE);
        re = cmd_pop && (cmd.op == OP_READ);
      end
      S_CP_RD: begin
        re    = 1'b1;
        raddr = cur.src + off;
      end
      S_CP_WR: begin
        we    = 1'b1;
        waddr = cur.dst + off;
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cur <= cmd;
            cnt <= '0;
            priority case (cmd.op)
              OP_READ: begin
                state <= S_RD;
              end
              OP_COPY: begin
                state <= S_CP_RD;
              end
              default: begin
                out_valid  <= 1'b1;
                read_value <= '0;
                copy_done  <= 1'b0;
              end
            endcase
          end
        end
        S_RD: begin
          out_valid  <= 1'b1;
          read_value <= rdata;
          copy_done  <= 1'b0;
          state      <= S_IDLE;
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == cur.len_m1) begin
            out_valid  <= 1'b1;
            read_value <= '0;
            copy_done  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_CP_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd_pop)
    else $error("command taken during clear pass");
  a_rd_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> out_valid)
    else $error("read produced no result");
  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_WR && cnt != cur.len_m1) |=> (state == S_CP_RD && !out_valid))
    else $error("copy ended early");
`endif

endmodule

@@ sv/ring_line_block_copy_engine_top.sv @@
// ----------------------------------------------------------------------------
// ring_line_block_copy_engine_top
// ring line store with pixel read, write and overlapping copy
// ----------------------------------------------------------------------------
// each word is executed in turn: a write in S_IDLE, a read through S_RD, a copy by
// alternating S_CP_RD and S_CP_WR (read then write per copied pixel); the next word
// is taken only once the previous result has been popped; queue holds 2 words
// reset: synchronous, active high; after reset a clear pass over all 1024 pixels
// zeroes the store, during which words queue but are not executed
module ring_line_block_copy_engine_top
  import rlbce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [ADDR_W-1:0] pixel_addr,
  input  logic [PIX_W-1:0]  pixel_value,
  input  logic [ADDR_W-1:0] copy_source,
  input  logic [ADDR_W-1:0] copy_dest,
  input  logic [LEN_W-1:0]  copy_length,
  output logic              empty,
  input  logic              pop,
  output logic [PIX_W-1:0]  read_value,
  output logic              copy_done
);

  // command word between front and back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic out_valid;

  // front: classify and queue
  rlbce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .pixel_addr  (pixel_addr),
    .pixel_value (pixel_value),
    .copy_source (copy_source),
    .copy_dest   (copy_dest),
    .copy_length (copy_length),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // back: store access, copy sequencing, result register
  rlbce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .read_value (read_value),
    .copy_done  (copy_done),
    .out_pop    (pop)
  );

  assign empty = !out_valid;

endmodule

@@ bench/ring_line_block_copy_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// ring_line_block_copy_engine_top_tb
// checks pixel write, read and overlapping ring copy against a local store
// model; directed table first, then random traffic with idling on both sides
// ----------------------------------------------------------------------------
module ring_line_block_copy_engine_top_tb;
  import rlbce_pkg::*;

  localparam int MAX_CYCLES = 4000000;
  localparam int RAND_WORDS = 600;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [LEN_W-1:0]  len;
    bit                typed;   // expected result given in the row
    logic [PIX_W-1:0]  exp_value;
    logic              exp_done;
  } stim_row_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             done;
  } line_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        opcode = OP_WRITE;
  logic [ADDR_W-1:0] pixel_addr = '0;
  logic [PIX_W-1:0]  pixel_value = '0;
  logic [ADDR_W-1:0] copy_source = '0;
  logic [ADDR_W-1:0] copy_dest = '0;
  logic [LEN_W-1:0]  copy_length = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [PIX_W-1:0]  read_value;
  logic              copy_done;

  // local model of the ring store
  logic [PIX_W-1:0] line_model [LINE_PIXELS];
  line_result_t     pending_results [$];
  stim_row_t        directed [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  copies_sent = 0;
  bit  no_idle = 1'b0;     // last part of the run: no gaps on either side
  bit  hold_off = 1'b0;    // long receiver stall, run from its own process
  bit  hold_done = 1'b0;

  ring_line_block_copy_engine_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .opcode(opcode), .pixel_addr(pixel_addr), .pixel_value(pixel_value),
    .copy_source(copy_source), .copy_dest(copy_dest), .copy_length(copy_length),
    .empty(empty), .pop(pop), .read_value(read_value), .copy_done(copy_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predict one word: updates the store and returns the expected result
  function automatic line_result_t apply_line_word(stim_row_t w);
    line_result_t r;
    int unsigned  n;
    r.value = '0;
    r.done  = 1'b0;
    case (w.op)
      OP_WRITE: line_model[w.addr] = w.value;
      OP_READ:  r.value = line_model[w.addr];
      OP_COPY: begin
        n = (w.len == 0 || w.len > LINE_PIXELS) ? LINE_PIXELS : w.len;
        // direction follows the sequential copy so overlap resolves the same
        if (w.dst <= w.src) begin
          for (int unsigned k = 0; k < n; k++)
            line_model[(w.dst + k) % LINE_PIXELS] = line_model[(w.src + k) % LINE_PIXELS];
        end else begin
          for (int unsigned k = n; k > 0; k--)
            line_model[(w.dst + k - 1) % LINE_PIXELS] =
              line_model[(w.src + k - 1) % LINE_PIXELS];
        end
        r.done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] op, int a, int v, int s, int d, int l);
    stim_row_t w;
    w.op = op; w.addr = ADDR_W'(a); w.value = PIX_W'(v);
    w.src = ADDR_W'(s); w.dst = ADDR_W'(d); w.len = LEN_W'(l);
    w.typed = 1'b0; w.exp_value = '0; w.exp_done = 1'b0;
    return w;
  endfunction

  function automatic stim_row_t mk_typed(logic [1:0] op, int a, int v, int s, int d, int l,
                                         int ev, int ed);
    stim_row_t w;
    w = mk_row(op, a, v, s, d, l);
    w.typed = 1'b1; w.exp_value = PIX_W'(ev); w.exp_done = (ed != 0);
    return w;
  endfunction

  // short copies mostly, a few full-line ones keep the run time sane
  function automatic stim_row_t rand_line_word();
    stim_row_t w;
    int        sel;
    int        l;
    sel = $urandom_range(99);
    if (sel < 40) w.op = OP_WRITE;
    else if (sel < 75) w.op = OP_READ;
    else if (sel < 97) w.op = OP_COPY;
    else w.op = OP_UNUSED;
    w.addr = ADDR_W'($urandom); w.value = PIX_W'($urandom);
    w.src = ADDR_W'($urandom); w.dst = ADDR_W'($urandom);
    if ($urandom_range(3) == 0) w.dst = ADDR_W'(w.src + $urandom_range(8) - 4);
    sel = $urandom_range(99);
    if (sel < 85) l = $urandom_range(1, 40);
    else if (sel < 90) l = 0;
    else if (sel < 95) l = $urandom_range(1025, 2047);
    else l = $urandom_range(41, 1024);
    w.len = LEN_W'(l);
    w.typed = 1'b0; w.exp_value = '0; w.exp_done = 1'b0;
    return w;
  endfunction

  task automatic send_line_word(stim_row_t w);
    line_result_t r;
    if (!no_idle && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 10)) @(negedge clk);
    opcode = w.op; pixel_addr = w.addr; pixel_value = w.value;
    copy_source = w.src; copy_dest = w.dst; copy_length = w.len;
    push = 1'b1;
    do @(posedge clk); while (full);
    r = apply_line_word(w);
    // a row with a typed result must agree with the model as well
    if (w.typed && (r.value !== w.exp_value || r.done !== w.exp_done)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees: op %0d want %h/%b model %h/%b",
                 w.op, w.exp_value, w.exp_done, r.value, r.done);
    end
    if (w.typed) begin
      r.value = w.exp_value; r.done = w.exp_done;
    end
    pending_results.push_back(r);
    words_sent++;
    if (w.op == OP_COPY) copies_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  // receiver: random bursts of stall, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        pop <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end else if (!no_idle && $urandom_range(4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    line_result_t e;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: read_value %h copy_done %b", read_value, copy_done);
      end else begin
        e = pending_results.pop_front();
        words_checked++;
        if (read_value !== e.value || copy_done !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: read_value exp %h got %h, copy_done exp %b got %b",
                     e.value, read_value, e.done, copy_done);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int tail;
    foreach (line_model[i]) line_model[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: extremes, every operation, wrap and overlap cases
    directed.push_back(mk_typed(OP_READ, 0, 0, 0, 0, 0, 0, 0));          // cleared after reset
    directed.push_back(mk_typed(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_WRITE, 0, 16'hFFFF, 0, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_READ, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    directed.push_back(mk_row(OP_WRITE, 1023, 16'h0001, 0, 0, 0));
    directed.push_back(mk_row(OP_WRITE, 1, 16'hA5A5, 0, 0, 0));
    directed.push_back(mk_row(OP_WRITE, 2, 16'h5A5A, 0, 0, 0));
    directed.push_back(mk_typed(OP_UNUSED, 0, 16'h1234, 5, 6, 7, 0, 0)); // unused opcode
    directed.push_back(mk_typed(OP_COPY, 0, 0, 1020, 0, 8, 0, 1));       // source wraps
    directed.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(OP_READ, 3, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 0, 1, 20, 0, 1));         // overlap, downward
    directed.push_back(mk_row(OP_READ, 20, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 3, 1, 20, 0, 1));         // overlap, upward
    directed.push_back(mk_row(OP_READ, 1, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 10, 1015, 17, 0, 1));     // dest wraps
    directed.push_back(mk_row(OP_READ, 1023, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 5, 5, 0, 0, 1));          // zero means full line
    directed.push_back(mk_typed(OP_COPY, 0, 0, 100, 7, 2047, 0, 1));     // long copy saturates
    directed.push_back(mk_row(OP_READ, 7, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 1023, 0, 1024, 0, 1));
    directed.push_back(mk_row(OP_READ, 512, 0, 0, 0, 0));
    directed.push_back(mk_typed(OP_COPY, 0, 0, 0, 1023, 1, 0, 1));
    directed.push_back(mk_row(OP_READ, 1023, 0, 0, 0, 0));
    foreach (directed[i]) send_line_word(directed[i]);

    // sender pause until everything is back
    wait (pending_results.size() == 0);

    // receiver holds off while writes keep coming, so the queue fills
    hold_off = 1'b1;
    repeat (20) send_line_word(mk_row(OP_WRITE, $urandom, $urandom, 0, 0, 0));
    wait (hold_done);
    hold_off = 1'b0;

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS - 100) no_idle = 1'b1;
      send_line_word(rand_line_word());
    end

    wait (pending_results.size() == 0);
    tail = 0;
    while (tail < 50) begin
      @(posedge clk);
      tail++;
    end
    $display("covered %0d words (%0d copies), %0d results checked, %0d mismatches",
             words_sent, copies_sent, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
